// ===== design/ssq_pkg.sv =====
// shared types and codes for the scroll step quantizer
// no dependencies; imported by the top level and its checker
package ssq_pkg;

	localparam int ACC_W   = 40;
	localparam int NOTCH_W = 32;
	localparam int THR_W   = 16;
	localparam int SURF_W  = 8;
	localparam int CNT_W   = 6;

	localparam logic [2:0] OP_ENTER = 3'd0;
	localparam logic [2:0] OP_LEAVE = 3'd1;
	localparam logic [2:0] OP_DELTA = 3'd2;
	localparam logic [2:0] OP_NOTCH = 3'd3;
	localparam logic [2:0] OP_FRAME = 3'd4;
	localparam logic [2:0] OP_STOP  = 3'd5;

	localparam logic [2:0] ADDR_REPORT_ENABLE  = 3'd0;
	localparam logic [2:0] ADDR_STEP_THRESHOLD = 3'd4;

	localparam logic [THR_W-1:0] THR_RESET = 16'd2560;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_FIX  = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

endpackage

// ===== design/scroll_step_quantizer.sv =====
// scroll step quantizer top level: accumulators, notch sums, focus and a
// shared bit-serial divider that turns accumulated motion into whole steps
// depends on ssq_pkg
//
// enter, leave, delta, notch, axis stop and unused codes: handled on accept, ready again next cycle
// frame with division: accept, then per axis 40 divider steps in ST_DIV plus a fix-up in ST_FIX
// (vertical then horizontal), then a push in ST_PUSH, where a nonzero result waits while the output
// register is still held; frame with notches or with reporting off: accept, then push
// one restoring subtract-and-compare unit, a 40-step loop per axis, sets the frame time
// arst_n clears all state, sets report_enable to 1 and step_threshold to 2560
module scroll_step_quantizer
	import ssq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// apb-style configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// event input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          opcode,
	input  logic                axis_select,
	input  logic signed [31:0]  delta,
	input  logic [SURF_W-1:0]   surface_id,
	// step result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  steps_vertical,
	output logic signed [31:0]  steps_horizontal,
	output logic [SURF_W-1:0]   target_surface
);

	// configuration registers
	logic               report_enable_q;
	logic [THR_W-1:0]   step_threshold_q;

	// scroll state
	logic [ACC_W-1:0]   acc_v_q, acc_h_q;
	logic [NOTCH_W-1:0] notch_v_q, notch_h_q;
	logic               notch_seen_q;
	logic [SURF_W-1:0]  focus_surface_q;
	logic               focus_valid_q;

	// sequencer and divider
	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               div_axis_q;   // 0 vertical pass, 1 horizontal pass
	logic               neg_q;        // sign of the dividend under division
	logic [ACC_W-1:0]   dvd_q;        // dividend in, quotient out
	logic [THR_W-1:0]   rem_q;

	// frame results waiting for the push cycle
	logic [31:0]        res_v_q, res_h_q;

	// output register
	logic               out_valid_q;
	logic [31:0]        out_v_q, out_h_q;
	logic [SURF_W-1:0]  out_surf_q;

	logic               in_acc;
	logic               cfg_wr;
	logic [THR_W-1:0]   thr_eff;

	assign pready   = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign cfg_wr   = psel && penable && pwrite;
	// a zero threshold counts as one
	assign thr_eff  = (step_threshold_q == '0) ? THR_W'(1) : step_threshold_q;

	assign out_valid        = out_valid_q;
	assign steps_vertical   = out_v_q;
	assign steps_horizontal = out_h_q;
	assign target_surface   = out_surf_q;

	always_comb begin
		case (paddr)
			ADDR_REPORT_ENABLE:  prdata = {31'd0, report_enable_q};
			ADDR_STEP_THRESHOLD: prdata = {16'd0, step_threshold_q};
			default:             prdata = '0;
		endcase
	end

	// saturating add of a delta to the selected accumulator
	logic [ACC_W-1:0]   acc_sel;
	logic [ACC_W:0]     acc_sum;
	logic [ACC_W-1:0]   acc_sat;

	assign acc_sel = axis_select ? acc_h_q : acc_v_q;
	assign acc_sum = {acc_sel[ACC_W-1], acc_sel} + {{(ACC_W+1-32){delta[31]}}, delta};

	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	// saturating add of a notch count to the selected notch sum
	logic [NOTCH_W-1:0] notch_sel;
	logic [NOTCH_W:0]   notch_sum;
	logic [NOTCH_W-1:0] notch_sat;

	assign notch_sel = axis_select ? notch_h_q : notch_v_q;
	assign notch_sum = {notch_sel[NOTCH_W-1], notch_sel} + {delta[31], delta};

	always_comb begin
		if (notch_sum[NOTCH_W] != notch_sum[NOTCH_W-1]) begin
			notch_sat = notch_sum[NOTCH_W] ? {1'b1, {(NOTCH_W-1){1'b0}}}
			                               : {1'b0, {(NOTCH_W-1){1'b1}}};
		end else begin
			notch_sat = notch_sum[NOTCH_W-1:0];
		end
	end

	// magnitude of the accumulator that the next division pass starts from;
	// the most negative value maps onto 2^39, which still fits unsigned
	logic [ACC_W-1:0]   load_src;
	logic [ACC_W-1:0]   load_mag;

	assign load_src = (state_q == ST_FIX) ? acc_h_q : acc_v_q;
	assign load_mag = load_src[ACC_W-1] ? (~load_src + ACC_W'(1)) : load_src;

	// one restoring division step: shift in the next dividend bit, try the subtract
	logic [THR_W:0]     trial;
	logic               q_bit;
	logic [THR_W-1:0]   rem_next;

	assign trial    = {rem_q, dvd_q[ACC_W-1]};
	assign q_bit    = (trial >= {1'b0, thr_eff});
	assign rem_next = q_bit ? THR_W'(trial - {1'b0, thr_eff}) : trial[THR_W-1:0];

	// fix-up: apply the sign, clamp the quotient to 32 bits, signed remainder
	logic [ACC_W-1:0]   q_signed;
	logic [31:0]        q_clamped;
	logic [ACC_W-1:0]   rem_signed;

	assign q_signed   = neg_q ? (~dvd_q + ACC_W'(1)) : dvd_q;
	assign rem_signed = neg_q ? (~{{(ACC_W-THR_W){1'b0}}, rem_q} + ACC_W'(1))
	                          :  {{(ACC_W-THR_W){1'b0}}, rem_q};

	always_comb begin
		if ($signed(q_signed) > $signed(ACC_W'(32'h7fff_ffff))) begin
			q_clamped = 32'h7fff_ffff;
		end else if ($signed(q_signed) < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000})) begin
			q_clamped = 32'h8000_0000;
		end else begin
			q_clamped = q_signed[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_enable_q  <= 1'b1;
			step_threshold_q <= THR_RESET;
			acc_v_q          <= '0;
			acc_h_q          <= '0;
			notch_v_q        <= '0;
			notch_h_q        <= '0;
			notch_seen_q     <= 1'b0;
			focus_surface_q  <= '0;
			focus_valid_q    <= 1'b0;
			state_q          <= ST_IDLE;
			cnt_q            <= '0;
			div_axis_q       <= 1'b0;
			neg_q            <= 1'b0;
			dvd_q            <= '0;
			rem_q            <= '0;
			res_v_q          <= '0;
			res_h_q          <= '0;
			out_valid_q      <= 1'b0;
			out_v_q          <= '0;
			out_h_q          <= '0;
			out_surf_q       <= '0;
		end else begin
			// configuration writes; the host must issue them only with no event in flight, the block does not enforce it
			if (cfg_wr) begin
				if (paddr == ADDR_REPORT_ENABLE) begin
					report_enable_q <= pwdata[0];
				end else if (paddr == ADDR_STEP_THRESHOLD) begin
					step_threshold_q <= pwdata[THR_W-1:0];
				end
			end

			// output transaction taken by the consumer
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (opcode)
							OP_ENTER: begin
								focus_surface_q <= surface_id;
								focus_valid_q   <= 1'b1;
								acc_v_q         <= '0;
								acc_h_q         <= '0;
								notch_v_q       <= '0;
								notch_h_q       <= '0;
								notch_seen_q    <= 1'b0;
							end
							OP_LEAVE: begin
								if (focus_valid_q && (focus_surface_q == surface_id)) begin
									focus_valid_q <= 1'b0;
								end
							end
							OP_DELTA: begin
								if (axis_select) begin
									acc_h_q <= acc_sat;
								end else begin
									acc_v_q <= acc_sat;
								end
							end
							OP_NOTCH: begin
								if (axis_select) begin
									notch_h_q <= notch_sat;
								end else begin
									notch_v_q <= notch_sat;
								end
								notch_seen_q <= 1'b1;
							end
							OP_FRAME: begin
								notch_v_q    <= '0;
								notch_h_q    <= '0;
								notch_seen_q <= 1'b0;
								if (!(report_enable_q && focus_valid_q)) begin
									// no report: push stage sees zero steps and drops it
									res_v_q <= '0;
									res_h_q <= '0;
									state_q <= ST_PUSH;
								end else if (notch_seen_q) begin
									res_v_q <= notch_v_q;
									res_h_q <= notch_h_q;
									acc_v_q <= '0;
									acc_h_q <= '0;
									state_q <= ST_PUSH;
								end else begin
									// start the vertical division pass
									dvd_q      <= load_mag;
									neg_q      <= acc_v_q[ACC_W-1];
									rem_q      <= '0;
									cnt_q      <= '0;
									div_axis_q <= 1'b0;
									state_q    <= ST_DIV;
								end
							end
							OP_STOP: begin
								if (axis_select) begin
									acc_h_q <= '0;
								end else begin
									acc_v_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					dvd_q <= {dvd_q[ACC_W-2:0], q_bit};
					rem_q <= rem_next;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ACC_W-1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (!div_axis_q) begin
						res_v_q <= q_clamped;
						acc_v_q <= rem_signed;
						// chain straight into the horizontal pass
						dvd_q      <= load_mag;
						neg_q      <= acc_h_q[ACC_W-1];
						rem_q      <= '0;
						cnt_q      <= '0;
						div_axis_q <= 1'b1;
						state_q    <= ST_DIV;
					end else begin
						res_h_q <= q_clamped;
						acc_h_q <= rem_signed;
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if ((res_v_q == '0) && (res_h_q == '0)) begin
						state_q <= ST_IDLE;
					end else if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_v_q     <= res_v_q;
						out_h_q     <= res_h_q;
						out_surf_q  <= focus_surface_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/ssq_checker.sv =====
// port-level checker for the scroll step quantizer, bound to the top level
// depends on ssq_pkg and scroll_step_quantizer
module ssq_checker
	import ssq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [2:0]         opcode,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] steps_vertical,
	input logic signed [31:0] steps_horizontal,
	input logic [SURF_W-1:0]  target_surface
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(steps_vertical)
			&& $stable(steps_horizontal) && $stable(target_surface))
		else $error("result changed while stalled");

	// empty frames never make a transaction
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (steps_vertical != 0) || (steps_horizontal != 0))
		else $error("result with zero steps on both axes");

	// a frame always takes the sequencer out of idle, so the input drops ready after it
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_FRAME) |=> !in_ready)
		else $error("ready straight after a frame transaction");

	// every other event finishes in its accept cycle
	a_event_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode != OP_FRAME) |=> in_ready)
		else $error("non-frame event stalled the input");

endmodule

bind scroll_step_quantizer ssq_checker u_ssq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.opcode           (opcode),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.steps_vertical   (steps_vertical),
	.steps_horizontal (steps_horizontal),
	.target_surface   (target_surface)
);

// ===== dv/tb.sv =====
// testbench for the scroll step quantizer: directed and random event streams with
// a step predictor held in a small scoreboard, and apb register writes between phases
// depends on ssq_pkg and scroll_step_quantizer
module tb;
	import ssq_pkg::*;

	localparam int     RESET_CYCLES = 7;
	localparam int     DRAIN_CYCLES = 150;
	localparam int     HOLD_CYCLES  = 600;
	localparam int     PHASE_EVENTS = 60;
	localparam int     SAT_PAIRS    = 258;	// 258 full-scale deltas pass 2^39 on each axis
	localparam longint RUN_LIMIT    = 64'd10_000_000;

	localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO   = -(longint'(1) <<< (ACC_W - 1));
	localparam longint NOTCH_HI = (longint'(1) <<< (NOTCH_W - 1)) - 1;
	localparam longint NOTCH_LO = -(longint'(1) <<< (NOTCH_W - 1));
	localparam longint STEP_HI  = 64'sd2147483647;
	localparam longint STEP_LO  = -64'sd2147483648;

	localparam logic [31:0] D_MAX = 32'h7fff_ffff;
	localparam logic [31:0] D_MIN = 32'h8000_0000;

	// receiver stall patterns
	localparam int RECV_ALWAYS = 0;
	localparam int RECV_MOSTLY = 1;
	localparam int RECV_SPARSE = 2;
	localparam int RECV_RUNS   = 3;

	typedef struct {
		logic signed [31:0] steps_v;
		logic signed [31:0] steps_h;
		logic [SURF_W-1:0]  surf;
	} step_report_t;

	// scroll state mirror: predicts the step report of each frame and holds the
	// reports still owed by the block
	class step_scoreboard;
		logic                      report_on;
		logic [THR_W-1:0]          threshold;
		logic signed [ACC_W-1:0]   acc_v;
		logic signed [ACC_W-1:0]   acc_h;
		logic signed [NOTCH_W-1:0] notch_v;
		logic signed [NOTCH_W-1:0] notch_h;
		logic                      notch_seen;
		logic [SURF_W-1:0]         focus_surf;
		logic                      focus_ok;
		step_report_t              pending_reports[$];
		int                        mismatches;
		int                        events_seen;
		int                        reports_seen;

		function new();
			report_on    = 1'b1;
			threshold    = THR_RESET;
			acc_v        = '0;
			acc_h        = '0;
			notch_v      = '0;
			notch_h      = '0;
			notch_seen   = 1'b0;
			focus_surf   = '0;
			focus_ok     = 1'b0;
			mismatches   = 0;
			events_seen  = 0;
			reports_seen = 0;
		endfunction

		function void write_reg(logic [2:0] addr, logic [31:0] value);
			if (addr == ADDR_REPORT_ENABLE)
				report_on = value[0];
			else if (addr == ADDR_STEP_THRESHOLD)
				threshold = value[THR_W-1:0];
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void clear_notches();
			notch_v    = '0;
			notch_h    = '0;
			notch_seen = 1'b0;
		endfunction

		function void note_event(logic [2:0] op, logic axis, logic signed [31:0] d,
				logic [SURF_W-1:0] surf);
			longint divisor;
			longint av;
			longint ah;
			longint qv;
			longint qh;
			longint sv;
			longint sh;
			step_report_t rep;
			events_seen++;
			case (op)
			OP_ENTER: begin
				focus_surf = surf;
				focus_ok   = 1'b1;
				acc_v      = '0;
				acc_h      = '0;
				clear_notches();
			end
			OP_LEAVE: begin
				if (focus_ok && focus_surf == surf)
					focus_ok = 1'b0;
			end
			OP_DELTA: begin
				if (axis)
					acc_h = ACC_W'(clamp(longint'(acc_h) + longint'(d), ACC_LO, ACC_HI));
				else
					acc_v = ACC_W'(clamp(longint'(acc_v) + longint'(d), ACC_LO, ACC_HI));
			end
			OP_NOTCH: begin
				if (axis)
					notch_h = NOTCH_W'(clamp(longint'(notch_h) + longint'(d),
						NOTCH_LO, NOTCH_HI));
				else
					notch_v = NOTCH_W'(clamp(longint'(notch_v) + longint'(d),
						NOTCH_LO, NOTCH_HI));
				notch_seen = 1'b1;
			end
			OP_FRAME: begin
				if (report_on && focus_ok) begin
					if (notch_seen) begin
						sv    = notch_v;
						sh    = notch_h;
						acc_v = '0;
						acc_h = '0;
					end else begin
						divisor = (threshold == 0) ? longint'(1) : longint'(threshold);
						av      = acc_v;
						ah      = acc_h;
						qv      = av / divisor;
						qh      = ah / divisor;
						acc_v   = ACC_W'(av - qv * divisor);
						acc_h   = ACC_W'(ah - qh * divisor);
						sv      = clamp(qv, STEP_LO, STEP_HI);
						sh      = clamp(qh, STEP_LO, STEP_HI);
					end
					if (sv != 0 || sh != 0) begin
						rep.steps_v = sv[31:0];
						rep.steps_h = sh[31:0];
						rep.surf    = focus_surf;
						pending_reports.push_back(rep);
					end
				end
				clear_notches();
			end
			OP_STOP: begin
				if (axis)
					acc_h = '0;
				else
					acc_v = '0;
			end
			default: ;
			endcase
		endfunction

		function void check_steps(logic signed [31:0] v, logic signed [31:0] h,
				logic [SURF_W-1:0] surf);
			step_report_t want;
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$error("step report with none pending: v %0d h %0d surface %0d", v, h, surf);
				mismatches++;
				return;
			end
			want = pending_reports.pop_front();
			if (v !== want.steps_v) begin
				$error("steps_vertical: expected %0d, got %0d", want.steps_v, v);
				mismatches++;
			end
			if (h !== want.steps_h) begin
				$error("steps_horizontal: expected %0d, got %0d", want.steps_h, h);
				mismatches++;
			end
			if (surf !== want.surf) begin
				$error("target_surface: expected %0d, got %0d", want.surf, surf);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         opcode;
	logic               axis_select;
	logic signed [31:0] delta;
	logic [SURF_W-1:0]  surface_id;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] steps_vertical;
	logic signed [31:0] steps_horizontal;
	logic [SURF_W-1:0]  target_surface;

	step_scoreboard sb;

	// sender pacing and receiver behaviour, set per phase
	bit sender_gaps;
	int burst_left;
	int recv_mode;
	bit hold_request;
	int run_left;
	bit run_level;

	scroll_step_quantizer uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#(RUN_LIMIT);
		$display("FAIL scroll_step_quantizer");
		$finish;
	end

	// result side: check every transaction, then pick the next ready level
	initial begin
		out_ready <= 1'b0;
		run_left = 0;
		run_level = 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_steps(steps_vertical, steps_horizontal, target_surface);
			if (hold_request) begin
				// long hold-off: output register fills, then the frame pipeline backs up
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				case (recv_mode)
				RECV_ALWAYS: out_ready <= 1'b1;
				RECV_MOSTLY: out_ready <= ($urandom_range(0, 9) < 8);
				RECV_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
				default: begin
					if (run_left == 0) begin
						run_level = $urandom_range(0, 1);
						run_left  = $urandom_range(1, 20);
					end
					run_left--;
					out_ready <= run_level;
				end
				endcase
			end
		end
	end

	// apb write with a setup and an access phase; the register takes the value at the access edge,
	// then the bus goes idle
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(addr, value);
		@(posedge clk);
	endtask

	// burst/gap pacing after each accepted event
	task automatic pace_sender();
		if (sender_gaps) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	// offer one event and hold it until the block takes it
	task automatic send_event(input logic [2:0] op, input logic axis,
			input logic [31:0] d, input logic [SURF_W-1:0] surf);
		in_valid    <= 1'b1;
		opcode      <= op;
		axis_select <= axis;
		delta       <= d;
		surface_id  <= surf;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_event(op, axis, d, surf);
		pace_sender();
	endtask

	// event whose other fields do not matter: fill them at random
	task automatic send_plain(input logic [2:0] op);
		send_event(op, 1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_axis(input logic [2:0] op, input logic axis, input logic [31:0] d);
		send_event(op, axis, d, 8'($urandom_range(0, 255)));
	endtask

	// wait for every owed report, then give a frame that reports nothing time to finish
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// deltas sized against the current threshold so frames often give steps
	function automatic logic [31:0] pick_delta();
		int unsigned span;
		int unsigned mag;
		int unsigned r;
		span = (sb.threshold == 0) ? 4 : 4 * sb.threshold;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			mag = $urandom_range(0, span);
			return $urandom_range(0, 1) ? -mag : mag;
		end
		if (r < 80)
			return $urandom_range(0, 511) - 256;
		if (r < 90)
			return $urandom;
		case ($urandom_range(0, 4))
		0:       return D_MAX;
		1:       return D_MIN;
		2:       return 32'h0;
		3:       return 32'hffff_ffff;
		default: return 32'h1;
		endcase
	endfunction

	function automatic logic [31:0] pick_notch();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 6) - 3;
		return $urandom;
	endfunction

	// well-formed group: maybe a focus change, a few scroll events, then a frame
	task automatic frame_group();
		int r;
		int k;
		bit notchy;
		r = $urandom_range(0, 99);
		if ((!sb.focus_ok && r < 70) || r < 8)
			send_event(OP_ENTER, 1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)));
		else if (r < 14)
			send_event(OP_LEAVE, 1'($urandom_range(0, 1)), $urandom,
				($urandom_range(0, 2) != 0) ? sb.focus_surf : 8'($urandom_range(0, 255)));
		k = $urandom_range(1, 5);
		notchy = ($urandom_range(0, 4) == 0);
		repeat (k) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				send_axis(OP_STOP, 1'($urandom_range(0, 1)), $urandom);
			else if (notchy && r < 12)
				send_axis(OP_NOTCH, 1'($urandom_range(0, 1)), pick_notch());
			else
				send_axis(OP_DELTA, 1'($urandom_range(0, 1)), pick_delta());
		end
		send_plain(OP_FRAME);
	endtask

	// one register setting, then mostly frame groups with some raw noise
	task automatic random_phase(input logic [15:0] thr, input logic enable,
			input int mode, input bit gaps);
		int first;
		apb_write(ADDR_REPORT_ENABLE, {31'd0, enable});
		apb_write(ADDR_STEP_THRESHOLD, {16'd0, thr});
		recv_mode   = mode;
		sender_gaps = gaps;
		first = sb.events_seen;
		while (sb.events_seen - first < PHASE_EVENTS) begin
			if ($urandom_range(0, 9) == 0)
				send_plain(3'($urandom_range(0, 7)));
			else
				frame_group();
		end
		settle();
	endtask

	// reset defaults: focus rules, draining, notch frames, stops and unused codes
	task automatic directed_basics();
		send_plain(OP_FRAME);				// no focus yet
		send_event(OP_ENTER, 1'b0, $urandom, 8'hff);
		send_axis(OP_DELTA, 1'b0, 32'd7685);		// three steps plus a remainder
		send_axis(OP_DELTA, 1'b1, -32'sd5121);	// truncation toward zero
		send_plain(OP_FRAME);
		send_plain(OP_FRAME);				// only remainders left: empty frame
		send_axis(OP_NOTCH, 1'b0, 32'd2);
		send_axis(OP_NOTCH, 1'b1, -32'sd1);
		send_plain(OP_FRAME);				// notches win and clear the accumulators
		send_axis(OP_NOTCH, 1'b0, 32'd0);
		send_plain(OP_FRAME);				// notch seen but zero sums
		send_axis(OP_DELTA, 1'b0, 32'd10240);
		send_axis(OP_STOP, 1'b0, $urandom);
		send_plain(OP_FRAME);				// axis stop discarded the motion
		send_event(OP_LEAVE, 1'b1, $urandom, 8'h00);	// wrong surface, focus kept
		send_axis(OP_DELTA, 1'b0, 32'd2560);
		send_plain(OP_FRAME);
		send_event(OP_LEAVE, 1'b0, $urandom, 8'hff);	// focus dropped
		send_axis(OP_DELTA, 1'b0, 32'd2560);
		send_plain(OP_FRAME);
		send_plain(3'd6);
		send_plain(3'd7);
		send_event(OP_ENTER, 1'b1, $urandom, 8'h00);
		send_axis(OP_NOTCH, 1'b0, D_MAX);
		send_axis(OP_NOTCH, 1'b0, D_MAX);		// notch sum saturates high
		send_axis(OP_NOTCH, 1'b1, D_MIN);
		send_axis(OP_NOTCH, 1'b1, D_MIN);		// and low
		send_plain(OP_FRAME);
	endtask

	initial begin
		sb = new();
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		opcode      <= OP_ENTER;
		axis_select <= 1'b0;
		delta       <= '0;
		surface_id  <= '0;
		sender_gaps  = 1'b1;
		burst_left   = 4;
		recv_mode    = RECV_MOSTLY;
		hold_request = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_basics();
		settle();

		// threshold of one: quotients beyond 32 bits are reported saturated
		apb_write(ADDR_REPORT_ENABLE, 32'd1);
		apb_write(ADDR_STEP_THRESHOLD, 32'd1);
		send_event(OP_ENTER, 1'b0, $urandom, 8'h3c);
		send_axis(OP_DELTA, 1'b0, D_MAX);
		send_axis(OP_DELTA, 1'b0, D_MAX);
		send_axis(OP_DELTA, 1'b1, D_MIN);
		send_axis(OP_DELTA, 1'b1, D_MIN);
		send_plain(OP_FRAME);
		send_plain(OP_FRAME);
		settle();

		// threshold of zero behaves as one
		apb_write(ADDR_STEP_THRESHOLD, 32'd0);
		send_axis(OP_DELTA, 1'b0, 32'd5);
		send_axis(OP_DELTA, 1'b1, -32'sd3);
		send_plain(OP_FRAME);
		settle();

		// reporting off while both accumulators run into saturation, then drain
		apb_write(ADDR_REPORT_ENABLE, 32'd0);
		send_event(OP_ENTER, 1'b0, $urandom, 8'hc3);
		repeat (SAT_PAIRS) begin
			send_axis(OP_DELTA, 1'b0, D_MAX);
			send_axis(OP_DELTA, 1'b1, D_MIN);
		end
		send_plain(OP_FRAME);
		settle();
		apb_write(ADDR_REPORT_ENABLE, 32'd1);
		send_plain(OP_FRAME);
		send_plain(OP_FRAME);
		settle();

		// random phases across the threshold range, one with reporting off
		random_phase(THR_RESET, 1'b1, RECV_ALWAYS, 1'b0);
		random_phase(16'hffff, 1'b1, RECV_RUNS, 1'b1);
		random_phase(16'd1, 1'b1, RECV_MOSTLY, 1'b1);
		random_phase(16'($urandom_range(2, 600)), 1'b0, RECV_SPARSE, 1'b1);
		random_phase(16'($urandom_range(100, 9000)), 1'b1, RECV_SPARSE, 1'b1);
		random_phase(16'($urandom_range(1, 65535)), 1'b1, RECV_RUNS, 1'b1);

		// back-pressure: receiver holds off while frames keep coming back to back
		apb_write(ADDR_STEP_THRESHOLD, {16'd0, THR_RESET});
		apb_write(ADDR_REPORT_ENABLE, 32'd1);
		sender_gaps = 1'b0;
		recv_mode   = RECV_MOSTLY;
		send_event(OP_ENTER, 1'b0, $urandom, 8'h5a);
		hold_request = 1'b1;
		repeat (20) begin
			send_axis(OP_DELTA, 1'($urandom_range(0, 1)), 32'd7687);
			send_plain(OP_FRAME);
		end
		settle();

		$display("covered %0d scroll events and %0d step reports over threshold, enable",
			sb.events_seen, sb.reports_seen);
		$display("and focus settings, saturation on both axes and a long output stall");
		if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
			$display("PASS scroll_step_quantizer");
		else
			$display("FAIL scroll_step_quantizer");
		$finish;
	end

endmodule
